// File: hdl/pebb_pkg.sv
// ----------------------------------------------------------------------------
// pebb_pkg
// Shared types, constants and fixed-point helpers for the particle step block.
// ----------------------------------------------------------------------------
package pebb_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_ENTITIES = 1024;

    localparam int DATA_W     = 32;
    localparam int DT_W       = 17;
    localparam int MAG_W      = 31;
    localparam int IDX_W      = 10;
    localparam int OP_W       = 2;
    localparam int MUL_B_W    = DT_W > MAG_W ? DT_W + 1 : MAG_W + 1;
    localparam int PROD_W     = DATA_W + MUL_B_W;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 328;
    localparam int M_TDATA_W  = 272;

    localparam logic [DT_W-1:0]          DT_RESET = DT_W'(1092);
    localparam logic signed [DATA_W-1:0] S_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN    = 32'sh8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_INTEGRATE,
        OP_COLLIDE,
        OP_FORCE,
        OP_CLEAR
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_INTEG,
        KIND_BOUNCE,
        KIND_FORCE,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [2:0] {
        REG_TIME_STEP,
        REG_BOUNDARY_ENABLE,
        REG_BOUND_LEFT,
        REG_BOUND_RIGHT,
        REG_BOUND_TOP,
        REG_BOUND_BOTTOM
    } reg_index_t;

    typedef struct packed {
        logic [DT_W-1:0]          time_step;
        logic                     boundary_enable;
        logic signed [DATA_W-1:0] bound_left;
        logic signed [DATA_W-1:0] bound_right;
        logic signed [DATA_W-1:0] bound_top;
        logic signed [DATA_W-1:0] bound_bottom;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] index;
    } ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] prev;
        logic                     hit;
    } lane_out_t;

    function automatic logic signed [DATA_W-1:0] sat_add_prod(
        input logic signed [DATA_W-1:0] base,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] sh;
        logic signed [PROD_W:0]   s;
        sh = prod >>> FRAC_BITS;
        s  = {{(PROD_W+1-DATA_W){base[DATA_W-1]}}, base} + {sh[PROD_W-1], sh};
        if (s[PROD_W:DATA_W-1] != {(PROD_W-DATA_W+2){s[DATA_W-1]}})
            return s[PROD_W] ? S_MIN : S_MAX;
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] s);
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? S_MIN : S_MAX;
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
        if (v == S_MIN)
            return S_MAX;
        return -v;
    endfunction

endpackage

// File: hdl/pebb_cfg.sv
// ----------------------------------------------------------------------------
// pebb_cfg
// APB register file: time step, boundary enable and the four box walls.
// ----------------------------------------------------------------------------
module pebb_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pebb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pebb_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pebb_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output pebb_pkg::cfg_t                      cfg
);
    import pebb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t sel_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign sel_index = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en     = psel & penable & pwrite & pready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel_index)
                REG_TIME_STEP:       cfg_next.time_step       = pwdata[DT_W-1:0];
                REG_BOUNDARY_ENABLE: cfg_next.boundary_enable = pwdata[0];
                REG_BOUND_LEFT:      cfg_next.bound_left      = pwdata;
                REG_BOUND_RIGHT:     cfg_next.bound_right     = pwdata;
                REG_BOUND_TOP:       cfg_next.bound_top       = pwdata;
                REG_BOUND_BOTTOM:    cfg_next.bound_bottom    = pwdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step       <= DT_RESET;
            cfg_reg.boundary_enable <= 1'b0;
            cfg_reg.bound_left      <= '0;
            cfg_reg.bound_right     <= S_MAX;
            cfg_reg.bound_top       <= '0;
            cfg_reg.bound_bottom    <= S_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (sel_index)
            REG_TIME_STEP:       prdata = CFG_DATA_W'(cfg_reg.time_step);
            REG_BOUNDARY_ENABLE: prdata = CFG_DATA_W'(cfg_reg.boundary_enable);
            REG_BOUND_LEFT:      prdata = cfg_reg.bound_left;
            REG_BOUND_RIGHT:     prdata = cfg_reg.bound_right;
            REG_BOUND_TOP:       prdata = cfg_reg.bound_top;
            REG_BOUND_BOTTOM:    prdata = cfg_reg.bound_bottom;
            default:             prdata = '0;
        endcase
    end

endmodule

// File: hdl/pebb_lane.sv
// ----------------------------------------------------------------------------
// pebb_lane
// One axis of the particle update: force/velocity product, saturating adds,
// wall test and clamp, acceleration clear, then the position product and final add.
// ----------------------------------------------------------------------------
module pebb_lane (
    input  logic                                clk,
    input  logic                                en1,
    input  logic                                en2,
    input  logic                                en3,
    input  pebb_pkg::kind_t                     kind0,
    input  pebb_pkg::kind_t                     kind1,
    input  pebb_pkg::kind_t                     kind3,
    input  logic [pebb_pkg::DT_W-1:0]           dt,
    input  logic signed [pebb_pkg::DATA_W-1:0]  bound_lo,
    input  logic signed [pebb_pkg::DATA_W-1:0]  bound_hi,
    input  logic signed [pebb_pkg::DATA_W-1:0]  pos,
    input  logic signed [pebb_pkg::DATA_W-1:0]  vel,
    input  logic signed [pebb_pkg::DATA_W-1:0]  acc,
    input  logic signed [pebb_pkg::DATA_W-1:0]  force_in,
    input  logic [pebb_pkg::MAG_W-1:0]          radius,
    input  logic [pebb_pkg::MAG_W-1:0]          inv_mass,
    output pebb_pkg::lane_out_t                 result
);
    import pebb_pkg::*;

    logic signed [DATA_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_B_W-1:0] dt_ext;
    logic signed [DATA_W:0]    lo_edge;
    logic signed [DATA_W:0]    hi_edge;
    logic signed [DATA_W:0]    blo_ext;
    logic signed [DATA_W:0]    bhi_ext;
    logic signed [DATA_W:0]    r_ext;
    logic                      hit0;
    logic signed [DATA_W-1:0]  clamp0;

    logic signed [PROD_W-1:0]  prod1_reg;
    logic signed [DATA_W-1:0]  pos1_reg, vel1_reg, acc1_reg, prev1_reg, clamp1_reg, vneg1_reg;
    logic                      hit1_reg;

    logic signed [DATA_W-1:0]  upd1;
    logic signed [DATA_W-1:0]  pos2_next, vel2_next, acc2_next;
    logic                      hit2_next;
    logic signed [DATA_W-1:0]  pos2_reg, vel2_reg, acc2_reg, prev2_reg;
    logic                      hit2_reg;

    logic signed [PROD_W-1:0]  prod3_reg;
    logic signed [DATA_W-1:0]  pos3_reg, vel3_reg, acc3_reg, prev3_reg;
    logic                      hit3_reg;

    assign dt_ext  = $signed({{(MUL_B_W-DT_W){1'b0}}, dt});
    assign r_ext   = $signed({2'b00, radius});
    assign blo_ext = {bound_lo[DATA_W-1], bound_lo};
    assign bhi_ext = {bound_hi[DATA_W-1], bound_hi};
    assign lo_edge = {pos[DATA_W-1], pos} - r_ext;
    assign hi_edge = {pos[DATA_W-1], pos} + r_ext;

    always_comb
    begin
        if (kind0 == KIND_FORCE)
        begin
            mul_a = force_in;
            mul_b = $signed({{(MUL_B_W-MAG_W){1'b0}}, inv_mass});
        end
        else
        begin
            mul_a = acc;
            mul_b = dt_ext;
        end
    end

    always_comb
    begin
        hit0   = 1'b0;
        clamp0 = pos;
        priority if (lo_edge < blo_ext)
        begin
            hit0   = 1'b1;
            clamp0 = sat33(blo_ext + r_ext);
        end
        else if (hi_edge > bhi_ext)
        begin
            hit0   = 1'b1;
            clamp0 = sat33(bhi_ext - r_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod1_reg  <= mul_a * mul_b;
            pos1_reg   <= pos;
            vel1_reg   <= vel;
            acc1_reg   <= acc;
            prev1_reg  <= pos;
            clamp1_reg <= clamp0;
            vneg1_reg  <= neg_sat(vel);
            hit1_reg   <= hit0;
        end
    end

    assign upd1 = sat_add_prod((kind1 == KIND_FORCE) ? acc1_reg : vel1_reg, prod1_reg);

    always_comb
    begin
        pos2_next = pos1_reg;
        vel2_next = vel1_reg;
        acc2_next = acc1_reg;
        hit2_next = 1'b0;
        unique case (kind1)
            KIND_INTEG:  vel2_next = upd1;
            KIND_FORCE:  acc2_next = upd1;
            KIND_CLEAR:  acc2_next = '0;
            KIND_BOUNCE:
            begin
                hit2_next = hit1_reg;
                if (hit1_reg)
                begin
                    pos2_next = clamp1_reg;
                    vel2_next = vneg1_reg;
                end
            end
            default:     pos2_next = pos1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            pos2_reg  <= pos2_next;
            vel2_reg  <= vel2_next;
            acc2_reg  <= acc2_next;
            prev2_reg <= prev1_reg;
            hit2_reg  <= hit2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            prod3_reg <= vel2_reg * dt_ext;
            pos3_reg  <= pos2_reg;
            vel3_reg  <= vel2_reg;
            acc3_reg  <= acc2_reg;
            prev3_reg <= prev2_reg;
            hit3_reg  <= hit2_reg;
        end
    end

    always_comb
    begin
        result.pos  = (kind3 == KIND_INTEG) ? sat_add_prod(pos3_reg, prod3_reg) : pos3_reg;
        result.vel  = vel3_reg;
        result.acc  = acc3_reg;
        result.prev = prev3_reg;
        result.hit  = hit3_reg;
    end

endmodule

// File: hdl/pebb_merge.sv
// ----------------------------------------------------------------------------
// pebb_merge
// Output register: packs both axis lanes into one result transfer.
// ----------------------------------------------------------------------------
module pebb_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [pebb_pkg::IDX_W-1:0]          index,
    input  pebb_pkg::lane_out_t                 lane_x,
    input  pebb_pkg::lane_out_t                 lane_y,
    output logic                                out_en,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pebb_pkg::M_TDATA_W-1:0]      m_tdata
);
    import pebb_pkg::*;

    localparam int PACK_W = IDX_W + 8 * DATA_W + 2;

    logic                 valid_reg;
    logic [M_TDATA_W-1:0] data_reg;
    logic [PACK_W-1:0]    packed_next;

    assign out_en   = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    assign packed_next = {lane_y.hit, lane_x.hit,
                          lane_y.prev, lane_x.prev,
                          lane_y.acc, lane_x.acc,
                          lane_y.vel, lane_x.vel,
                          lane_y.pos, lane_x.pos,
                          index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && in_valid)
            data_reg <= {{(M_TDATA_W-PACK_W){1'b0}}, packed_next};
    end

endmodule

// File: hdl/particle_euler_step_box_bounce.sv
// ----------------------------------------------------------------------------
// particle_euler_step_box_bounce
// Path: each input passes the lane stage registers and the output register.
// Throughput: one record per cycle unless the output stalls; each stage holds
//   independently, so a stalled output only stops the stages behind it once they fill up.
// Reset: rst_n clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module particle_euler_step_box_bounce (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pebb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pebb_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pebb_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entity_index[9:0] pos_x[41:10] pos_y[73:42] vel_x[105:74] vel_y[137:106]
    // acc_x[169:138] acc_y[201:170] radius[232:202] force_x[264:233]
    // force_y[296:265] inv_mass[327:297]
    input  logic [pebb_pkg::S_TDATA_W-1:0]      s_tdata,
    // opcode[1:0]
    input  logic [pebb_pkg::OP_W-1:0]           s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // entity_index_out[9:0] new_pos_x[41:10] new_pos_y[73:42] new_vel_x[105:74]
    // new_vel_y[137:106] new_acc_x[169:138] new_acc_y[201:170]
    // prev_pos_x[233:202] prev_pos_y[265:234] hit_x[266] hit_y[267] zero[271:268]
    output logic [pebb_pkg::M_TDATA_W-1:0]      m_tdata
);
    import pebb_pkg::*;

    cfg_t      cfg;
    ctrl_t     ctrl0;
    ctrl_t     ctrl1_reg, ctrl2_reg, ctrl3_reg;
    logic      valid1_reg, valid2_reg, valid3_reg;
    logic      en1, en2, en3, out_en;
    logic      accept;
    opcode_t   opcode;
    logic      in_range;
    lane_out_t lane_x, lane_y;

    logic [IDX_W-1:0]         entity_index;
    logic signed [DATA_W-1:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, force_x, force_y;
    logic [MAG_W-1:0]         radius, inv_mass;

    assign entity_index = s_tdata[9:0];
    assign pos_x        = s_tdata[41:10];
    assign pos_y        = s_tdata[73:42];
    assign vel_x        = s_tdata[105:74];
    assign vel_y        = s_tdata[137:106];
    assign acc_x        = s_tdata[169:138];
    assign acc_y        = s_tdata[201:170];
    assign radius       = s_tdata[232:202];
    assign force_x      = s_tdata[264:233];
    assign force_y      = s_tdata[296:265];
    assign inv_mass     = s_tdata[327:297];
    assign opcode       = opcode_t'(s_tuser);

    assign in_range = 32'(entity_index) < 32'(MAX_ENTITIES);

    always_comb
    begin
        ctrl0.index = entity_index;
        if (!in_range)
            ctrl0.kind = KIND_PASS;
        else
        begin
            unique case (opcode)
                OP_INTEGRATE: ctrl0.kind = KIND_INTEG;
                OP_COLLIDE:   ctrl0.kind = cfg.boundary_enable ? KIND_BOUNCE : KIND_PASS;
                OP_FORCE:     ctrl0.kind = KIND_FORCE;
                OP_CLEAR:     ctrl0.kind = KIND_CLEAR;
                default:      ctrl0.kind = KIND_PASS;
            endcase
        end
    end

    assign en3      = !valid3_reg || out_en;
    assign en2      = !valid2_reg || en3;
    assign en1      = !valid1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                valid1_reg <= accept;
            if (en2)
                valid2_reg <= valid1_reg;
            if (en3)
                valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            ctrl1_reg <= ctrl0;
        if (en2)
            ctrl2_reg <= ctrl1_reg;
        if (en3)
            ctrl3_reg <= ctrl2_reg;
    end

    pebb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pebb_lane u_lane_x (
        .clk      (clk),
        .en1      (en1),
        .en2      (en2),
        .en3      (en3),
        .kind0    (ctrl0.kind),
        .kind1    (ctrl1_reg.kind),
        .kind3    (ctrl3_reg.kind),
        .dt       (cfg.time_step),
        .bound_lo (cfg.bound_left),
        .bound_hi (cfg.bound_right),
        .pos      (pos_x),
        .vel      (vel_x),
        .acc      (acc_x),
        .force_in (force_x),
        .radius   (radius),
        .inv_mass (inv_mass),
        .result   (lane_x)
    );

    pebb_lane u_lane_y (
        .clk      (clk),
        .en1      (en1),
        .en2      (en2),
        .en3      (en3),
        .kind0    (ctrl0.kind),
        .kind1    (ctrl1_reg.kind),
        .kind3    (ctrl3_reg.kind),
        .dt       (cfg.time_step),
        .bound_lo (cfg.bound_top),
        .bound_hi (cfg.bound_bottom),
        .pos      (pos_y),
        .vel      (vel_y),
        .acc      (acc_y),
        .force_in (force_y),
        .radius   (radius),
        .inv_mass (inv_mass),
        .result   (lane_y)
    );

    pebb_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid3_reg),
        .index    (ctrl3_reg.index),
        .lane_x   (lane_x),
        .lane_y   (lane_y),
        .out_en   (out_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sim/particle_step_checker.sv
// ----------------------------------------------------------------------------
// particle_step_checker
// Watches the register port and both record streams of the particle step
// block. For every input transfer it computes the updated particle record from
// its own copy of the registers and queues it. Each output transfer is checked
// field by field against the oldest queued record.
// ----------------------------------------------------------------------------
module particle_step_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [pebb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pebb_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // entity_index pos_x pos_y vel_x vel_y acc_x acc_y radius force_x force_y inv_mass
    input  logic [pebb_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic [pebb_pkg::OP_W-1:0]       s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // entity_index_out new_pos_x/y new_vel_x/y new_acc_x/y prev_pos_x/y hit_x hit_y zero
    input  logic [pebb_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pebb_pkg::*;

    localparam longint WORD_MAX = 2147483647;
    localparam longint WORD_MIN = -WORD_MAX - 1;

    typedef struct packed {
        logic [30:0]        inv_mass;
        logic signed [31:0] force_y;
        logic signed [31:0] force_x;
        logic [30:0]        radius;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic [9:0]         index;
    } particle_rec_t;

    typedef struct packed {
        logic [3:0]         zero;
        logic               hit_y;
        logic               hit_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic [9:0]         index;
    } step_result_t;

    longint       step_dt;
    logic         walls_on;
    longint       wall_left;
    longint       wall_right;
    longint       wall_top;
    longint       wall_bottom;
    step_result_t expected_records[$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic longint clamp32(longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // exact product, then floor toward minus infinity
    function automatic longint fix_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    function automatic step_result_t advance_particle(opcode_t op, particle_rec_t rec);
        step_result_t res;
        longint       px, py, vx, vy, ax, ay, r;
        logic         hx, hy;
        px = rec.pos_x;
        py = rec.pos_y;
        vx = rec.vel_x;
        vy = rec.vel_y;
        ax = rec.acc_x;
        ay = rec.acc_y;
        r  = longint'(rec.radius);
        hx = 1'b0;
        hy = 1'b0;
        if (rec.index < MAX_ENTITIES) begin
            case (op)
                OP_INTEGRATE:
                begin
                    vx = clamp32(vx + fix_mul(ax, step_dt));
                    vy = clamp32(vy + fix_mul(ay, step_dt));
                    px = clamp32(px + fix_mul(vx, step_dt));
                    py = clamp32(py + fix_mul(vy, step_dt));
                end
                OP_COLLIDE:
                begin
                    if (walls_on) begin
                        if (px - r < wall_left) begin
                            px = clamp32(wall_left + r);
                            hx = 1'b1;
                        end
                        else if (px + r > wall_right) begin
                            px = clamp32(wall_right - r);
                            hx = 1'b1;
                        end
                        if (py - r < wall_top) begin
                            py = clamp32(wall_top + r);
                            hy = 1'b1;
                        end
                        else if (py + r > wall_bottom) begin
                            py = clamp32(wall_bottom - r);
                            hy = 1'b1;
                        end
                        if (hx)
                            vx = clamp32(-vx);
                        if (hy)
                            vy = clamp32(-vy);
                    end
                end
                OP_FORCE:
                begin
                    ax = clamp32(ax + fix_mul(longint'(rec.force_x), longint'(rec.inv_mass)));
                    ay = clamp32(ay + fix_mul(longint'(rec.force_y), longint'(rec.inv_mass)));
                end
                default:
                begin
                    ax = 0;
                    ay = 0;
                end
            endcase
        end
        res.zero   = '0;
        res.hit_y  = hy;
        res.hit_x  = hx;
        res.prev_y = rec.pos_y;
        res.prev_x = rec.pos_x;
        res.acc_y  = ay[31:0];
        res.acc_x  = ax[31:0];
        res.vel_y  = vy[31:0];
        res.vel_x  = vx[31:0];
        res.pos_y  = py[31:0];
        res.pos_x  = px[31:0];
        res.index  = rec.index;
        return res;
    endfunction

    task automatic check_field(string name, logic [9:0] index, logic [31:0] want,
                               logic [31:0] got);
        if (want !== got) begin
            $display("%0t: entity %0d %s expected %h, got %h", $realtime, index, name,
                     want, got);
            fail_count++;
        end
    endtask

    task automatic compare_record(step_result_t want, step_result_t got);
        check_field("entity_index_out", want.index, 32'(want.index), 32'(got.index));
        check_field("new_pos_x", want.index, want.pos_x, got.pos_x);
        check_field("new_pos_y", want.index, want.pos_y, got.pos_y);
        check_field("new_vel_x", want.index, want.vel_x, got.vel_x);
        check_field("new_vel_y", want.index, want.vel_y, got.vel_y);
        check_field("new_acc_x", want.index, want.acc_x, got.acc_x);
        check_field("new_acc_y", want.index, want.acc_y, got.acc_y);
        check_field("prev_pos_x", want.index, want.prev_x, got.prev_x);
        check_field("prev_pos_y", want.index, want.prev_y, got.prev_y);
        check_field("hit_x", want.index, 32'(want.hit_x), 32'(got.hit_x));
        check_field("hit_y", want.index, 32'(want.hit_y), 32'(got.hit_y));
        check_field("padding", want.index, 32'(want.zero), 32'(got.zero));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_dt     = 1092;
            walls_on    = 1'b0;
            wall_left   = 0;
            wall_right  = WORD_MAX;
            wall_top    = 0;
            wall_bottom = WORD_MAX;
            expected_records.delete();
            pending     = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, got %h",
                             $realtime, m_tdata);
                    fail_count++;
                end
                else
                    compare_record(expected_records.pop_front(), step_result_t'(m_tdata));
            end
            if (s_tvalid && s_tready)
                expected_records.push_back(
                    advance_particle(opcode_t'(s_tuser), particle_rec_t'(s_tdata)));
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[4:2]))
                    REG_TIME_STEP:       step_dt     = longint'(pwdata[DT_W-1:0]);
                    REG_BOUNDARY_ENABLE: walls_on    = pwdata[0];
                    REG_BOUND_LEFT:      wall_left   = longint'($signed(pwdata));
                    REG_BOUND_RIGHT:     wall_right  = longint'($signed(pwdata));
                    REG_BOUND_TOP:       wall_top    = longint'($signed(pwdata));
                    REG_BOUND_BOTTOM:    wall_bottom = longint'($signed(pwdata));
                    default:             ;
                endcase
            end
            pending = expected_records.size();
        end
    end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the particle step block with directed records at the field extremes
// and for every opcode and wall case, then with random records over several
// register settings. Input bursts, output stalls and one long output hold-off
// exercise back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pebb_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 250;
    localparam int PHASE_COUNT  = 6;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [30:0]        inv_mass;
        logic signed [31:0] force_y;
        logic signed [31:0] force_x;
        logic [30:0]        radius;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic [9:0]         index;
    } particle_rec_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // entity_index pos_x pos_y vel_x vel_y acc_x acc_y radius force_x force_y inv_mass
    logic [S_TDATA_W-1:0]  s_tdata;
    // opcode
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // entity_index_out new_pos_x/y new_vel_x/y new_acc_x/y prev_pos_x/y hit_x hit_y zero
    logic [M_TDATA_W-1:0]  m_tdata;
    int                    fail_count;
    int                    pending;
    int                    sent_count;
    int                    burst_left;
    int                    cycle_count;

    particle_euler_step_box_bounce u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    particle_step_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial cycle_count = 0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return 32'h0;
            3, 4, 5: return $urandom;
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_mag();
        case ($urandom_range(0, 7))
            0:       return 31'h7FFF_FFFF;
            1:       return 31'h0;
            2:       return 31'h0001_0000;
            3, 4:    return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h0010_0000));
        endcase
    endfunction

    function automatic particle_rec_t random_record();
        particle_rec_t rec;
        rec.index    = 10'($urandom);
        rec.pos_x    = rand_q16();
        rec.pos_y    = rand_q16();
        rec.vel_x    = rand_q16();
        rec.vel_y    = rand_q16();
        rec.acc_x    = rand_q16();
        rec.acc_y    = rand_q16();
        rec.radius   = rand_mag();
        rec.force_x  = rand_q16();
        rec.force_y  = rand_q16();
        rec.inv_mass = rand_mag();
        return rec;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_record(opcode_t op, particle_rec_t rec);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rec;
        do @(posedge clk); while (!s_tready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure_phase(int phase);
        logic [31:0] cx, cy, half_w, half_h;
        if (phase == 0)
            write_reg(REG_TIME_STEP, 32'd0);
        else if (phase == 1)
            write_reg(REG_TIME_STEP, 32'd65536);
        else
            write_reg(REG_TIME_STEP, $urandom_range(0, 65536));
        write_reg(REG_BOUNDARY_ENABLE, (phase == 2) ? 32'd0 : 32'd1);
        cx     = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        cy     = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        half_w = $urandom_range(0, 32'h0100_0000);
        half_h = $urandom_range(0, 32'h0100_0000);
        if (phase == 1) begin
            write_reg(REG_BOUND_LEFT, S_MIN);
            write_reg(REG_BOUND_RIGHT, S_MAX);
            write_reg(REG_BOUND_TOP, S_MIN);
            write_reg(REG_BOUND_BOTTOM, S_MAX);
        end
        else if (phase == 3) begin
            write_reg(REG_BOUND_LEFT, S_MAX);
            write_reg(REG_BOUND_RIGHT, S_MIN);
            write_reg(REG_BOUND_TOP, S_MAX);
            write_reg(REG_BOUND_BOTTOM, S_MIN);
        end
        else begin
            write_reg(REG_BOUND_LEFT, cx - half_w);
            write_reg(REG_BOUND_RIGHT, cx + half_w);
            write_reg(REG_BOUND_TOP, cy - half_h);
            write_reg(REG_BOUND_BOTTOM, cy + half_h);
        end
    endtask

    // receiver: stall pattern changes every stretch; one long hold-off
    initial begin
        bit held_off;
        int mode;
        int span;
        held_off = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge clk);
                if (!held_off && sent_count >= HOLD_AT) begin
                    held_off = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        particle_rec_t rec;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        sent_count = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: default step, walls off
        rec = '0;
        send_record(OP_INTEGRATE, rec);
        rec.index    = 10'd1023;
        rec.pos_x    = S_MAX;
        rec.pos_y    = S_MIN;
        rec.vel_x    = S_MAX;
        rec.vel_y    = S_MIN;
        rec.acc_x    = S_MAX;
        rec.acc_y    = S_MIN;
        rec.radius   = 31'h7FFF_FFFF;
        rec.force_x  = S_MAX;
        rec.force_y  = S_MIN;
        rec.inv_mass = 31'h7FFF_FFFF;
        send_record(OP_INTEGRATE, rec);
        send_record(OP_COLLIDE, rec);
        send_record(OP_FORCE, rec);
        send_record(OP_CLEAR, rec);
        // small negatives round toward minus infinity
        rec = '0;
        rec.vel_x    = -32'sd1;
        rec.acc_x    = -32'sd1;
        rec.force_x  = -32'sd1;
        rec.inv_mass = 31'd1;
        send_record(OP_INTEGRATE, rec);
        send_record(OP_FORCE, rec);
        drain();

        // unit step, walls at +-100.0 by +-50.0
        write_reg(REG_TIME_STEP, 32'd65536);
        write_reg(REG_BOUNDARY_ENABLE, 32'd1);
        write_reg(REG_BOUND_LEFT, 32'hFF9C_0000);
        write_reg(REG_BOUND_RIGHT, 32'h0064_0000);
        write_reg(REG_BOUND_TOP, 32'hFFCE_0000);
        write_reg(REG_BOUND_BOTTOM, 32'h0032_0000);
        rec = '0;
        rec.radius = 31'h0001_0000;
        send_record(OP_COLLIDE, rec);
        rec.pos_x = 32'hFF9C_0000;
        rec.pos_y = 32'h0032_0000;
        rec.vel_x = S_MIN;
        rec.vel_y = 32'h0003_0000;
        send_record(OP_COLLIDE, rec);
        rec.pos_x = 32'h0064_0000;
        rec.pos_y = 32'hFFCE_0000;
        rec.vel_x = 32'hFFFB_0000;
        rec.vel_y = S_MIN;
        send_record(OP_COLLIDE, rec);
        rec.pos_x  = S_MAX;
        rec.pos_y  = S_MIN;
        rec.radius = 31'h7FFF_FFFF;
        send_record(OP_COLLIDE, rec);
        rec.pos_x  = 32'h0;
        rec.pos_y  = 32'h0;
        send_record(OP_COLLIDE, rec);
        rec.pos_x = S_MAX;
        rec.vel_x = 32'h0000_0001;
        rec.acc_y = S_MIN;
        send_record(OP_INTEGRATE, rec);
        drain();

        // zero step, walls at the extremes of the range
        write_reg(REG_TIME_STEP, 32'd0);
        write_reg(REG_BOUND_LEFT, S_MIN);
        write_reg(REG_BOUND_RIGHT, S_MAX);
        write_reg(REG_BOUND_TOP, S_MAX);
        write_reg(REG_BOUND_BOTTOM, S_MIN);
        rec = random_record();
        send_record(OP_INTEGRATE, rec);
        rec = '0;
        rec.pos_x  = S_MIN;
        rec.radius = 31'd1;
        send_record(OP_COLLIDE, rec);
        rec.pos_x  = S_MAX;
        rec.pos_y  = S_MIN;
        rec.radius = 31'd0;
        send_record(OP_COLLIDE, rec);
        drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            configure_phase(phase);
            repeat (PHASE_ITEMS)
                send_record(opcode_t'($urandom_range(0, 3)), random_record());
            drain();
        end

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: particle_euler_step_box_bounce.f
hdl/pebb_pkg.sv
hdl/pebb_cfg.sv
hdl/pebb_lane.sv
hdl/pebb_merge.sv
hdl/particle_euler_step_box_bounce.sv
sim/particle_step_checker.sv
sim/tb.sv
